// File: hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and helpers for the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int unsigned KeyBytes = 19;
  localparam int unsigned KeyW     = KeyBytes * 8;
  localparam int unsigned ValW     = 32;

  typedef enum logic [1:0] {
    CMD_SET      = 2'd0,
    CMD_GET      = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the request
    logic match;     // compare the request key against every entry
    logic update;    // write back and start the value read
    logic load_out;  // move the response into the output register
  } kvt_cmd_t;

  // Clears every byte that follows the first zero byte, as a string compare would.
  function automatic logic [KeyW-1:0] normalize_key(input logic [KeyW-1:0] raw);
    logic [KeyW-1:0] res;
    logic            ended;
    logic [7:0]      b;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < KeyBytes; i++) begin
      b = raw[i*8 +: 8];
      if (ended) begin
        b = 8'h00;
      end
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      res[i*8 +: 8] = b;
    end
    return res;
  endfunction

endpackage

// File: hdl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer for one request: match, write back, respond.
// ----------------------------------------------------------------------------
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kvt_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_req = in_valid_i && (state_q == S_IDLE);
    cmd_o.match    = (state_q == S_MATCH);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.load_out = (state_q == S_RESP) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new response may replace the one leaving in the same cycle.
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A response only appears as the sequencer leaves its response step.
  a_resp_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("response raised outside the response step");

  // Every accepted request passes through the match step and then reaches the write-back step.
  a_update_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 (state_q == S_UPDATE))
    else $error("write-back did not follow an accepted request");

  // The response step never ends without filling the output register.
  a_resp_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> out_valid_q)
    else $error("response lost");

endmodule

// File: hdl/kvt_dpath.sv
// ----------------------------------------------------------------------------
// kvt_dpath
// Key store with parallel match, value memory and response register.
// ----------------------------------------------------------------------------
module kvt_dpath
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kvt_cmd_t               cmd_i,
  input  logic [1:0]             req_cmd_i,
  input  logic [KeyW-1:0]        req_key_i,
  input  logic signed [ValW-1:0] req_value_i,
  output logic [1:0]             status_o,
  output logic signed [ValW-1:0] read_value_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Request registers.
  cmd_e            req_cmd_q;
  logic [KeyW-1:0] req_key_q;
  logic [ValW-1:0] req_val_q;

  // Entry storage. Keys sit in flops so every entry can be compared at once.
  logic [KeyW-1:0] key_q [ENTRIES];
  logic [ValW-1:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  logic [ENTRIES-1:0] hit_vec_q;
  logic [ENTRIES-1:0] free_vec_q;

  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;
  logic [IdxW-1:0] wr_idx;
  logic            hit_any;
  logic            free_any;
  logic            val_we;
  logic            key_we;
  logic            del_en;
  status_e         stat_d;

  status_e         resp_stat_q;
  logic            resp_rv_q;
  logic [ValW-1:0] rdata_q;
  status_e         out_stat_q;
  logic [ValW-1:0] out_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_cmd_q <= cmd_e'(req_cmd_i);
      req_key_q <= normalize_key(req_key_i);
      req_val_q <= req_value_i;
    end
  end

  // Match vector and free vector are registered before any encoding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vec_q  <= '0;
      free_vec_q <= '0;
    end else if (cmd_i.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec_q[i]  <= valid_q[i] && (key_q[i] == req_key_q);
        free_vec_q[i] <= !valid_q[i];
      end
    end
  end

  // At most one entry matches, so the hit index is a plain OR of indexes.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign hit_any  = |hit_vec_q;
  assign free_any = |free_vec_q;

  assign val_we = cmd_i.update && (req_cmd_q == CMD_SET) && (hit_any || free_any);
  assign key_we = cmd_i.update && (req_cmd_q == CMD_SET) && !hit_any && free_any;
  assign del_en = cmd_i.update && (req_cmd_q == CMD_DELETE) && hit_any;
  assign wr_idx = hit_any ? hit_idx : free_idx;

  always_comb begin
    case (req_cmd_q)
      CMD_SET: stat_d = (hit_any || free_any) ? ST_OK : ST_FULL;
      default: stat_d = hit_any ? ST_OK : ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[free_idx] <= req_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= req_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rdata_q <= val_mem[hit_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (key_we) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (del_en) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      resp_stat_q <= stat_d;
      resp_rv_q   <= (req_cmd_q == CMD_GET) && hit_any;
    end
    if (cmd_i.load_out) begin
      out_stat_q <= resp_stat_q;
      out_val_q  <= resp_rv_q ? rdata_q : '0;
    end
  end

  assign status_o     = out_stat_q;
  assign read_value_o = out_val_q;

  // A key is stored in at most one valid entry.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec_q))
    else $error("request key matched more than one entry");

  // An insert fills exactly one more entry.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("insert did not add exactly one entry");

  // A delete that hits frees exactly one entry.
  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_en |=> ($countones(valid_q) + 1 == $past($countones(valid_q))))
    else $error("delete did not free exactly one entry");

endmodule

// File: hdl/key_value_table_top.sv
// ----------------------------------------------------------------------------
// key_value_table_top
// Associative table of keys up to 19 characters with signed 32-bit values.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   request | in        | in_valid_i / in_ready_o | cmd, key_part0..2, new_value
//   response| out       | out_valid_o / out_ready_i | status, read_value
//
// A request passes through accept, key match over all entries, write-back
// with the value memory read, and the response register load, in that order.
// The next request is taken in the cycle after the response is loaded, so the
// table holds one transaction at a time; the match vector and the read of the
// value memory are both registered.
// Reset clears all valid bits at once; keys and values need no clearing.
// A stalled response holds the sequencer in its response step.
// ----------------------------------------------------------------------------
module key_value_table_top
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [63:0]        key_part0_i,
  input  logic [63:0]        key_part1_i,
  input  logic [23:0]        key_part2_i,
  input  logic signed [31:0] new_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o
);

  kvt_cmd_t        cmd;
  logic [KeyW-1:0] raw_key;

  assign raw_key = {key_part2_i, key_part1_i, key_part0_i};

  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  kvt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_cmd_i    (cmd_i),
    .req_key_i    (raw_key),
    .req_value_i  (new_value_i),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

endmodule
